[design/gvmc_pkg.sv]
// Package for the gap-verify motion controller: field widths, codes,
// register indexes, reset values, the payload structs of both channels and the statistics control struct.
// No dependencies.
package gvmc_pkg;

  localparam int MEAS_W             = 16;  // Q12.4 distance width
  localparam int COUNT_BITS_DEFAULT = 12;
  localparam int MIN_SAMPLES_W      = 12;
  localparam int RATIO_W            = 9;   // Q1.8, 256 means one
  localparam int CFG_INDEX_W        = 3;
  localparam int CFG_DATA_W         = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP_THRESHOLD  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERIFY_TRAVEL  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SAMPLES    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GOOD_RATIO = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_STOP     = 3'd4;

  // Configuration reset values
  localparam logic [MEAS_W-1:0]        GAP_THRESHOLD_RST  = 16'd320;
  localparam logic [MEAS_W-1:0]        VERIFY_TRAVEL_RST  = 16'd160;
  localparam logic [MIN_SAMPLES_W-1:0] MIN_SAMPLES_RST    = 12'd5;
  localparam logic [RATIO_W-1:0]       MIN_GOOD_RATIO_RST = 9'd179;
  localparam logic [MEAS_W-1:0]        FRONT_STOP_RST     = 16'd160;

  // Side motor commands
  localparam logic signed [1:0] CMD_STOP  = 2'sb00;
  localparam logic signed [1:0] CMD_RIGHT = 2'sb01;
  localparam logic signed [1:0] CMD_LEFT  = 2'sb11;

  typedef enum logic [1:0] {
    MODE_SIDE    = 2'd0,
    MODE_VERIFY  = 2'd1,
    MODE_FORWARD = 2'd2
  } mode_t;

  typedef struct packed {
    logic [MEAS_W-1:0] gap_distance;
    logic              sample_fresh;
    logic              left_bumper;
    logic              right_bumper;
    logic [MEAS_W-1:0] side_travel;
    logic [MEAS_W-1:0] front_distance;
  } sensor_item_t;

  typedef struct packed {
    logic signed [1:0] side_drive;
    logic              forward_drive;
    logic [1:0]        mode;
    logic              clear_side_odometry;
    logic              clear_forward_odometry;
  } drive_item_t;

  // Controls from the mode logic to the statistics unit
  typedef struct packed {
    logic update;      // item is being retired this cycle
    logic clear;       // zero the statistics
    logic accumulate;  // fold in the current fresh sample
    logic good;        // current sample is at or above threshold
  } stats_ctl_t;

endpackage

[design/gvmc_stream_if.sv]
// Valid/ready stream interface used for both channels of the controller.
// Payload type is given per instance; depends on nothing else.
interface gvmc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/gap_verify_motion_controller.sv]
// Top level of the gap-verify motion controller: config registers, input
// register, mode logic and result register. Depends on gvmc_pkg,
// gvmc_stream_if and gvmc_stats.
//
//  channel  role    payload        transfer when
//  -------  ------  -------------  ----------------------------
//  sensor   sink    sensor_item_t  sensor.valid && sensor.ready
//  drive    source  drive_item_t   drive.valid && drive.ready
//  cfg_*    write   index + data   cfg_we high at the clock edge
//
// A transfer lands in the input register; when the result register can take
// it, the mode logic and statistics update and the result is registered,
// raising drive.valid. Throughput is one tick per cycle while drive does not
// stall; the limit is the state feedback through the confirm multipliers.
// rst is synchronous and restores the config defaults, side mode, direction
// right and both motors stopped. A stalled result register holds the input
// register, which in turn drops sensor.ready; no transfer is ever dropped.
module gap_verify_motion_controller import gvmc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  gvmc_stream_if.sink            sensor,
  gvmc_stream_if.source          drive,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [MEAS_W-1:0]        gap_threshold;
  logic [MEAS_W-1:0]        verify_travel;
  logic [MIN_SAMPLES_W-1:0] min_samples;
  logic [RATIO_W-1:0]       min_good_ratio;
  logic [MEAS_W-1:0]        front_stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold  <= GAP_THRESHOLD_RST;
      verify_travel  <= VERIFY_TRAVEL_RST;
      min_samples    <= MIN_SAMPLES_RST;
      min_good_ratio <= MIN_GOOD_RATIO_RST;
      front_stop     <= FRONT_STOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAP_THRESHOLD:  gap_threshold  <= cfg_data;
        CFG_VERIFY_TRAVEL:  verify_travel  <= cfg_data;
        CFG_MIN_SAMPLES:    min_samples    <= cfg_data[MIN_SAMPLES_W-1:0];
        CFG_MIN_GOOD_RATIO: min_good_ratio <= cfg_data[RATIO_W-1:0];
        CFG_FRONT_STOP:     front_stop     <= cfg_data;
        default: ;  // writes past the register list are ignored
      endcase
    end
  end

  // Pipeline handshake: input register feeds result register
  logic         in_valid;
  sensor_item_t in_item;
  logic         res_valid;
  drive_item_t  res_item;
  logic         advance;

  assign advance      = in_valid && (!res_valid || drive.ready);
  assign sensor.ready = !in_valid || advance;
  assign drive.valid  = res_valid;
  assign drive.payload = res_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sensor.ready) begin
      in_valid <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor.valid && sensor.ready) begin
      in_item <= sensor.payload;
    end
  end

  // Controller state
  mode_t             mode, mode_next;
  logic              direction_right, direction_right_next;
  logic signed [1:0] side_cmd, side_cmd_next;
  logic              forward_cmd, forward_cmd_next;
  logic              clr_side, clr_fwd;
  stats_ctl_t        stats_ctl;
  logic              confirmed;
  logic              gap_open, bumped, travel_done, front_blocked;

  assign gap_open      = in_item.gap_distance >= gap_threshold;
  assign bumped        = in_item.left_bumper || in_item.right_bumper;
  assign travel_done   = in_item.side_travel >= verify_travel;
  assign front_blocked = in_item.front_distance <= front_stop;

  gvmc_stats #(
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk            (clk),
    .rst            (rst),
    .ctl            (stats_ctl),
    .gap_distance   (in_item.gap_distance),
    .gap_threshold  (gap_threshold),
    .min_samples    (min_samples),
    .min_good_ratio (min_good_ratio),
    .confirmed      (confirmed)
  );

  // Next mode
  always_comb begin
    unique case (mode)
      MODE_VERIFY: begin
        if (bumped) begin
          mode_next = MODE_SIDE;          // bumper abort
        end else if (travel_done) begin
          mode_next = confirmed ? MODE_FORWARD : MODE_SIDE;
        end else begin
          mode_next = MODE_VERIFY;
        end
      end
      MODE_FORWARD: mode_next = front_blocked ? MODE_SIDE : MODE_FORWARD;
      default:      mode_next = gap_open ? MODE_VERIFY : MODE_SIDE;
    endcase
  end

  // Motor commands, direction, odometry clears and statistics control
  always_comb begin
    direction_right_next = direction_right;
    side_cmd_next        = side_cmd;
    forward_cmd_next     = forward_cmd;
    clr_side             = 1'b0;
    clr_fwd              = 1'b0;
    stats_ctl.update     = advance;
    stats_ctl.clear      = 1'b0;
    stats_ctl.accumulate = 1'b0;
    stats_ctl.good       = gap_open;
    unique case (mode)
      MODE_VERIFY: begin
        forward_cmd_next = 1'b0;
        if (bumped) begin
          // side command holds for this tick; direction follows bumpers
          direction_right_next = in_item.left_bumper;
          clr_side             = 1'b1;
          stats_ctl.clear      = 1'b1;
        end else begin
          side_cmd_next        = direction_right ? CMD_RIGHT : CMD_LEFT;
          stats_ctl.accumulate = in_item.sample_fresh;
          if (travel_done && confirmed) begin
            side_cmd_next = CMD_STOP;
            clr_fwd       = 1'b1;
          end
        end
      end
      MODE_FORWARD: begin
        side_cmd_next    = CMD_STOP;
        forward_cmd_next = !front_blocked;
      end
      default: begin
        forward_cmd_next = 1'b0;
        if (in_item.left_bumper) begin
          direction_right_next = 1'b1;
        end else if (in_item.right_bumper) begin
          direction_right_next = 1'b0;
        end
        side_cmd_next = direction_right_next ? CMD_RIGHT : CMD_LEFT;
        if (gap_open) begin
          clr_side        = 1'b1;
          stats_ctl.clear = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_SIDE;
      direction_right <= 1'b1;
      side_cmd        <= CMD_STOP;
      forward_cmd     <= 1'b0;
    end else if (advance) begin
      mode            <= mode_next;
      direction_right <= direction_right_next;
      side_cmd        <= side_cmd_next;
      forward_cmd     <= forward_cmd_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (drive.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item.side_drive             <= side_cmd_next;
      res_item.forward_drive          <= forward_cmd_next;
      res_item.mode                   <= mode_next;
      res_item.clear_side_odometry    <= clr_side;
      res_item.clear_forward_odometry <= clr_fwd;
    end
  end

endmodule

[design/gvmc_stats.sv]
// Verify statistics: saturating sample/good counters, distance sum and the
// gap confirmation check by cross-multiplication. Depends on gvmc_pkg.
module gvmc_stats import gvmc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  stats_ctl_t               ctl,
  input  logic [MEAS_W-1:0]        gap_distance,
  input  logic [MEAS_W-1:0]        gap_threshold,
  input  logic [MIN_SAMPLES_W-1:0] min_samples,
  input  logic [RATIO_W-1:0]       min_good_ratio,
  output logic                     confirmed
);

  localparam int SUM_W   = MEAS_W + COUNT_BITS;
  localparam int CMP_W   = (COUNT_BITS > MIN_SAMPLES_W) ? COUNT_BITS : MIN_SAMPLES_W;
  localparam int RPROD_W = COUNT_BITS + RATIO_W;

  logic [COUNT_BITS-1:0] sample_count, sample_count_next;
  logic [COUNT_BITS-1:0] good_count, good_count_next;
  logic [SUM_W-1:0]      distance_sum, distance_sum_next;
  logic [SUM_W:0]        sum_wide;
  logic [RPROD_W-1:0]    good_scaled, ratio_prod;
  logic [SUM_W-1:0]      avg_prod;
  logic                  count_ok, ratio_ok, avg_ok;

  // Accumulated values; equal to the stored ones when nothing is folded in
  always_comb begin
    sample_count_next = sample_count;
    good_count_next   = good_count;
    distance_sum_next = distance_sum;
    sum_wide          = {1'b0, distance_sum} + (SUM_W+1)'(gap_distance);
    if (ctl.accumulate) begin
      if (sample_count != '1) begin
        sample_count_next = sample_count + COUNT_BITS'(1);
      end
      if (ctl.good && (good_count != '1)) begin
        good_count_next = good_count + COUNT_BITS'(1);
      end
      distance_sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    good_scaled = RPROD_W'({good_count_next, 8'b0});
    ratio_prod  = RPROD_W'(min_good_ratio) * RPROD_W'(sample_count_next);
    avg_prod    = SUM_W'(gap_threshold) * SUM_W'(sample_count_next);
    count_ok    = CMP_W'(sample_count_next) >= CMP_W'(min_samples);
    if (sample_count_next == '0) begin
      // no samples: ratio and average count as zero
      ratio_ok = (min_good_ratio == '0);
      avg_ok   = (gap_threshold == '0);
    end else begin
      ratio_ok = good_scaled >= ratio_prod;
      avg_ok   = distance_sum_next >= avg_prod;
    end
    confirmed = count_ok && ratio_ok && avg_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      good_count   <= '0;
      distance_sum <= '0;
    end else if (ctl.update) begin
      if (ctl.clear) begin
        sample_count <= '0;
        good_count   <= '0;
        distance_sum <= '0;
      end else begin
        sample_count <= sample_count_next;
        good_count   <= good_count_next;
        distance_sum <= distance_sum_next;
      end
    end
  end

endmodule

[dv/gap_verify_motion_controller_tb.sv]
`timescale 1ns / 100ps
// Testbench for gap_verify_motion_controller: drives sensor ticks, predicts each
// drive result in place and compares it field by field.
// Depends on gvmc_pkg, gvmc_stream_if and the controller RTL.
module gap_verify_motion_controller_tb;
  import gvmc_pkg::*;

  // narrow counters so saturation is reached in a short run
  localparam int CNT_BITS = 8;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
  localparam longint unsigned SUM_MAX = (64'd1 << (MEAS_W + CNT_BITS)) - 1;
  localparam int CYCLE_LIMIT = 800_000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS = 180;

  // receiver back-pressure styles
  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC, RX_LONG} rx_style_e;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  gvmc_stream_if #(.payload_t(sensor_item_t)) sensor_ch ();
  gvmc_stream_if #(.payload_t(drive_item_t))  drive_ch ();

  gap_verify_motion_controller #(
    .COUNT_BITS (CNT_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .sensor    (sensor_ch),
    .drive     (drive_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Known values on every block input from time zero.
  initial begin
    sensor_ch.valid   = 1'b0;
    sensor_ch.payload = '0;
    drive_ch.ready    = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the controller registers and config.
  // ---------------------------------------------------------------------------
  logic [MEAS_W-1:0]          thr_gap      = GAP_THRESHOLD_RST;
  logic [MEAS_W-1:0]          thr_travel   = VERIFY_TRAVEL_RST;
  logic [MIN_SAMPLES_W-1:0]   need_samples = MIN_SAMPLES_RST;
  logic [RATIO_W-1:0]         need_ratio   = MIN_GOOD_RATIO_RST;
  logic [MEAS_W-1:0]          stop_front   = FRONT_STOP_RST;

  mode_t                      ctl_mode      = MODE_SIDE;
  logic                       ctl_dir_right = 1'b1;
  logic signed [1:0]          ctl_side      = CMD_STOP;
  logic                       ctl_fwd       = 1'b0;
  logic [CNT_BITS-1:0]        stat_samples  = '0;
  logic [CNT_BITS-1:0]        stat_good     = '0;
  logic [MEAS_W+CNT_BITS-1:0] stat_sum      = '0;

  drive_item_t drive_expect_q[$];
  drive_item_t got_item;
  drive_item_t want_item;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          ticks_sent = 0;

  // sender burst control
  int burst_left = 0;
  bit src_idle_on = 1'b1;

  // receiver stall pattern
  rx_style_e rx_style = RX_OPEN;
  int        rx_left = 0;
  int        rx_hold = 0;
  logic      rx_level = 1'b1;

  function automatic void clear_stats();
    stat_samples = '0;
    stat_good    = '0;
    stat_sum     = '0;
  endfunction

  // left bumper wins when both are pressed
  function automatic void steer_from_bumpers(input logic left, input logic right);
    if (left) ctl_dir_right = 1'b1;
    else if (right) ctl_dir_right = 1'b0;
  endfunction

  // Gap acceptance: count floor, good ratio and average, all by
  // cross-multiplication. With no samples ratio and average count as zero.
  function automatic bit gap_passes();
    bit count_ok, ratio_ok, avg_ok;
    longint unsigned n, good, sum;
    n    = 64'(stat_samples);
    good = 64'(stat_good);
    sum  = 64'(stat_sum);
    count_ok = n >= longint'(need_samples);
    if (n == 0) begin
      ratio_ok = (need_ratio == 0);
      avg_ok   = (thr_gap == 0);
    end else begin
      ratio_ok = good * 256 >= longint'(need_ratio) * n;
      avg_ok   = sum >= longint'(thr_gap) * n;
    end
    return count_ok && ratio_ok && avg_ok;
  endfunction

  // Advances the predicted controller by one tick and returns its drive result.
  function automatic drive_item_t advance_controller(input sensor_item_t s);
    drive_item_t     r;
    logic            clr_side, clr_fwd;
    longint unsigned sum_wide;
    clr_side = 1'b0;
    clr_fwd  = 1'b0;
    case (ctl_mode)
      MODE_VERIFY: begin
        ctl_fwd = 1'b0;
        if (s.left_bumper || s.right_bumper) begin
          // abort: motor keeps last command this tick
          steer_from_bumpers(s.left_bumper, s.right_bumper);
          clr_side = 1'b1;
          clear_stats();
          ctl_mode = MODE_SIDE;
        end else begin
          ctl_side = ctl_dir_right ? CMD_RIGHT : CMD_LEFT;
          if (s.sample_fresh) begin
            if (stat_samples != CNT_MAX) stat_samples = stat_samples + 1'b1;
            sum_wide = longint'(stat_sum) + longint'(s.gap_distance);
            stat_sum = (MEAS_W+CNT_BITS)'((sum_wide > SUM_MAX) ? SUM_MAX : sum_wide);
            if (s.gap_distance >= thr_gap && stat_good != CNT_MAX)
              stat_good = stat_good + 1'b1;
          end
          if (s.side_travel >= thr_travel) begin
            if (gap_passes()) begin
              ctl_side = CMD_STOP;
              clr_fwd  = 1'b1;
              ctl_mode = MODE_FORWARD;
            end else begin
              // rejected: statistics stay until next verify entry
              ctl_mode = MODE_SIDE;
            end
          end
        end
      end
      MODE_FORWARD: begin
        ctl_side = CMD_STOP;
        if (s.front_distance <= stop_front) begin
          ctl_fwd  = 1'b0;
          ctl_mode = MODE_SIDE;
        end else begin
          ctl_fwd = 1'b1;
        end
      end
      default: begin
        // side mode; the unused mode code lands here as well
        ctl_mode = MODE_SIDE;
        ctl_fwd  = 1'b0;
        steer_from_bumpers(s.left_bumper, s.right_bumper);
        ctl_side = ctl_dir_right ? CMD_RIGHT : CMD_LEFT;
        if (s.gap_distance >= thr_gap) begin
          clr_side = 1'b1;
          clear_stats();
          ctl_mode = MODE_VERIFY;
        end
      end
    endcase
    r.side_drive             = ctl_side;
    r.forward_drive          = ctl_fwd;
    r.mode                   = ctl_mode;
    r.clear_side_odometry    = clr_side;
    r.clear_forward_odometry = clr_fwd;
    return r;
  endfunction

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0d] %s", cycle_count, what);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard: every sensor transfer queues a prediction, every
  // drive transfer is checked against the oldest one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (sensor_ch.valid && sensor_ch.ready)
        drive_expect_q.push_back(advance_controller(sensor_ch.payload));
      if (drive_ch.valid && drive_ch.ready) begin
        got_item = drive_ch.payload;
        if (drive_expect_q.size() == 0) begin
          report_failure("drive transfer with no sensor tick pending");
        end else begin
          want_item = drive_expect_q.pop_front();
          if (got_item.side_drive !== want_item.side_drive ||
              got_item.forward_drive !== want_item.forward_drive ||
              got_item.mode !== want_item.mode ||
              got_item.clear_side_odometry !== want_item.clear_side_odometry ||
              got_item.clear_forward_odometry !== want_item.clear_forward_odometry)
            // fields: side/fwd/mode/clear side/clear forward
            report_failure($sformatf(
              "drive mismatch exp %0d/%0b/%0d/%0b/%0b got %0d/%0b/%0d/%0b/%0b",
              want_item.side_drive, want_item.forward_drive, want_item.mode,
              want_item.clear_side_odometry, want_item.clear_forward_odometry,
              got_item.side_drive, got_item.forward_drive, got_item.mode,
              got_item.clear_side_odometry, got_item.clear_forward_odometry));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: switches between stall styles at random,
  // including open stretches with no stalls at all.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_e'($urandom_range(4, 0));
      rx_left  = $urandom_range(300, 40);
    end
    rx_left--;
    case (rx_style)
      RX_OPEN:     drive_ch.ready <= 1'b1;
      RX_COIN:     drive_ch.ready <= 1'($urandom_range(1, 0));
      RX_MOSTLY:   drive_ch.ready <= ($urandom_range(9, 0) != 0);
      RX_PERIODIC: drive_ch.ready <= (rx_left % 4) != 0;
      default: begin
        if (rx_hold == 0) begin
          rx_level = ~rx_level;
          rx_hold  = $urandom_range(12, 1);
        end
        rx_hold--;
        drive_ch.ready <= rx_level;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // One sensor transfer. Valid stays up after the handshake; every caller
  // either sends again or drops valid at the very next falling edge.
  task automatic send_tick(input sensor_item_t t);
    int idle_n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      idle_n = src_idle_on ? $urandom_range(8, 0) : 0;
      repeat (idle_n) begin
        @(negedge clk);
        sensor_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    sensor_ch.valid   <= 1'b1;
    sensor_ch.payload <= t;
    do @(posedge clk); while (!sensor_ch.ready);
    ticks_sent++;
  endtask

  // Stop sending and wait until every queued result has been checked.
  task automatic wait_for_drive_idle();
    @(negedge clk);
    sensor_ch.valid <= 1'b0;
    burst_left = 0;
    while (drive_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Writes all five registers while the block is idle.
  task automatic set_config(input logic [MEAS_W-1:0] gap_thr,
                            input logic [MEAS_W-1:0] travel,
                            input logic [MIN_SAMPLES_W-1:0] samples,
                            input logic [RATIO_W-1:0] ratio,
                            input logic [MEAS_W-1:0] front);
    wait_for_drive_idle();
    write_reg(CFG_GAP_THRESHOLD, gap_thr);
    write_reg(CFG_VERIFY_TRAVEL, travel);
    write_reg(CFG_MIN_SAMPLES, CFG_DATA_W'(samples));
    write_reg(CFG_MIN_GOOD_RATIO, CFG_DATA_W'(ratio));
    write_reg(CFG_FRONT_STOP, front);
    @(negedge clk);
    cfg_we <= 1'b0;
    thr_gap      = gap_thr;
    thr_travel   = travel;
    need_samples = samples;
    need_ratio   = ratio;
    stop_front   = front;
  endtask

  function automatic sensor_item_t make_tick(input int gap, input bit fresh,
                                             input bit left, input bit right,
                                             input int travel, input int front);
    sensor_item_t t;
    t.gap_distance   = MEAS_W'(gap);
    t.sample_fresh   = fresh;
    t.left_bumper    = left;
    t.right_bumper   = right;
    t.side_travel    = MEAS_W'(travel);
    t.front_distance = MEAS_W'(front);
    return t;
  endfunction

  function automatic sensor_item_t random_tick();
    return make_tick($urandom, $urandom_range(1, 0), $urandom_range(1, 0),
                     $urandom_range(1, 0), $urandom, $urandom);
  endfunction

  // value strictly under lim (lim > 0), often right at the edge
  function automatic logic [MEAS_W-1:0] pick_below(input logic [MEAS_W-1:0] lim);
    if ($urandom_range(3, 0) == 0) return lim - 1'b1;
    return MEAS_W'($urandom_range(int'(lim) - 1, 0));
  endfunction

  // value at or above lim, often exactly lim
  function automatic logic [MEAS_W-1:0] pick_at_least(input logic [MEAS_W-1:0] lim);
    if ($urandom_range(3, 0) == 0) return lim;
    return MEAS_W'($urandom_range(65535, int'(lim)));
  endfunction

  function automatic logic [MEAS_W-1:0] pick_distance_cfg();
    case ($urandom_range(4, 0))
      0:       return '0;
      1:       return '1;
      2:       return MEAS_W'($urandom);
      default: return MEAS_W'($urandom_range(2000, 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset config: a full side -> verify -> forward -> side cycle, bumper
  // steering (left wins over right), a bumper abort and a rejected gap.
  task automatic test_default_drive_cycle();
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
    send_tick(make_tick(319, 1, 0, 1, 100, 500));   // steer left
    send_tick(make_tick(100, 0, 1, 1, 0, 0));       // both pressed: right
    send_tick(make_tick(320, 0, 0, 0, 0, 0));       // gap exactly at threshold
    send_tick(make_tick(400, 1, 0, 0, 0, 0));
    send_tick(make_tick(100, 1, 0, 0, 10, 0));      // fresh but not good
    send_tick(make_tick(65535, 0, 0, 0, 20, 0));    // stale sample ignored
    send_tick(make_tick(500, 1, 0, 0, 30, 0));
    send_tick(make_tick(320, 1, 0, 0, 159, 0));
    send_tick(make_tick(330, 1, 0, 0, 160, 0));     // travel reached: confirmed
    send_tick(make_tick(0, 1, 1, 1, 0, 65535));     // forward ignores bumpers
    send_tick(make_tick(0, 0, 0, 0, 0, 161));
    send_tick(make_tick(0, 0, 0, 0, 0, 160));       // front at stop value
    send_tick(make_tick(65535, 0, 0, 1, 0, 0));     // steer left, enter verify
    send_tick(make_tick(0, 1, 1, 1, 0, 0));         // bumper abort
    send_tick(make_tick(320, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 1, 0, 0, 65535, 0));     // too few samples: rejected
    wait_for_drive_idle();
  endtask

  // All-zero limits (confirm with no samples at all), then all-max limits with
  // a good ratio above one that can never be met.
  task automatic test_config_extremes();
    set_config('0, '0, '0, '0, '0);
    send_tick(make_tick(0, 0, 1, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
    set_config('1, '1, 12'd1, '1, '1);
    send_tick(make_tick(65535, 1, 0, 0, 0, 1));
    send_tick(make_tick(65535, 1, 0, 0, 65535, 65535));
    send_tick(make_tick(65534, 1, 0, 1, 65535, 0));
    wait_for_drive_idle();
  endtask

  // Long verify run so sample count, good count and distance sum all pin at
  // their maxima, then a confirm at the strictest count and ratio limits.
  task automatic test_counter_saturation();
    sensor_item_t t;
    set_config(16'd61000, '1, MIN_SAMPLES_W'(CNT_MAX), 9'd256, '1);
    src_idle_on = 1'b1;
    t = random_tick();
    t.gap_distance = pick_at_least(16'd61000);
    send_tick(t);
    repeat (int'(CNT_MAX) + 64) begin
      t = random_tick();
      t.left_bumper  = 1'b0;
      t.right_bumper = 1'b0;
      t.sample_fresh = ($urandom_range(15, 0) != 0);
      t.gap_distance = MEAS_W'($urandom_range(65535, 63000));
      t.side_travel  = MEAS_W'($urandom_range(65534, 0));
      send_tick(t);
    end
    send_tick(make_tick(65535, 1, 0, 0, 65535, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 65535));
    wait_for_drive_idle();
  endtask

  // One drive session: side search, verify window, forward run. A minority of
  // sessions are pure noise.
  task automatic run_session();
    sensor_item_t t;
    int           n_side, n_verify, n_fwd, lim;
    bit           aborted;
    if ($urandom_range(7, 0) == 0) begin
      repeat ($urandom_range(8, 1)) send_tick(random_tick());
      return;
    end
    n_side = (thr_gap == 0) ? 0 : $urandom_range(4, 0);
    repeat (n_side) begin
      t = random_tick();
      t.gap_distance = pick_below(thr_gap);
      t.left_bumper  = ($urandom_range(3, 0) == 0);
      t.right_bumper = ($urandom_range(3, 0) == 0);
      send_tick(t);
    end
    t = random_tick();
    t.gap_distance = pick_at_least(thr_gap);
    send_tick(t);

    lim = (need_samples > 16) ? 16 : int'(need_samples);
    n_verify = (thr_travel == 0) ? 0 : $urandom_range(lim + 4, 0);
    aborted = 1'b0;
    for (int k = 0; k < n_verify && !aborted; k++) begin
      t = random_tick();
      t.sample_fresh = ($urandom_range(3, 0) != 0);
      if (thr_gap == 0 || $urandom_range(1, 0) == 0) t.gap_distance = pick_at_least(thr_gap);
      else t.gap_distance = pick_below(thr_gap);
      t.side_travel = pick_below(thr_travel);
      aborted = ($urandom_range(15, 0) == 0);
      if (!aborted) begin
        t.left_bumper  = 1'b0;
        t.right_bumper = 1'b0;
      end else if (!t.left_bumper && !t.right_bumper) begin
        t.right_bumper = 1'b1;
      end
      send_tick(t);
    end
    if (aborted) return;

    t = random_tick();
    t.left_bumper  = 1'b0;
    t.right_bumper = 1'b0;
    t.sample_fresh = ($urandom_range(3, 0) != 0);
    t.gap_distance = ($urandom_range(2, 0) != 0 || thr_gap == 0) ?
                     pick_at_least(thr_gap) : pick_below(thr_gap);
    t.side_travel  = pick_at_least(thr_travel);
    send_tick(t);

    n_fwd = (stop_front == '1) ? 0 : $urandom_range(5, 0);
    repeat (n_fwd) begin
      t = random_tick();
      t.front_distance = MEAS_W'($urandom_range(65535, int'(stop_front) + 1));
      send_tick(t);
    end
    t = random_tick();
    t.front_distance = ($urandom_range(2, 0) == 0) ? stop_front :
                       MEAS_W'($urandom_range(int'(stop_front), 0));
    send_tick(t);
  endtask

  task automatic test_random_sessions();
    logic [MIN_SAMPLES_W-1:0] samples;
    logic [RATIO_W-1:0]       ratio;
    int                       phase_end;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(4, 0))
        0:       samples = '0;
        1:       samples = '1;
        default: samples = MIN_SAMPLES_W'($urandom_range(12, 0));
      endcase
      case ($urandom_range(5, 0))
        0:       ratio = '0;
        1:       ratio = 9'd256;
        2:       ratio = '1;
        3:       ratio = RATIO_W'($urandom_range(511, 257));
        default: ratio = RATIO_W'($urandom_range(256, 0));
      endcase
      set_config(pick_distance_cfg(), pick_distance_cfg(), samples, ratio,
                 pick_distance_cfg());
      src_idle_on = ($urandom_range(3, 0) != 0);
      phase_end = ticks_sent + PHASE_TICKS;
      while (ticks_sent < phase_end) begin
        run_session();
        // sender holds off until the pipeline is empty now and then
        if ($urandom_range(30, 0) == 0) wait_for_drive_idle();
      end
    end
    wait_for_drive_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_drive_cycle();
    test_config_extremes();
    test_counter_saturation();
    test_random_sessions();

    wait_for_drive_idle();
    repeat (20) @(posedge clk);
    if (drive_expect_q.size() != 0)
      report_failure($sformatf("%0d drive results never arrived", drive_expect_q.size()));

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/gvmc_pkg.sv
design/gvmc_stream_if.sv
design/gvmc_stats.sv
design/gap_verify_motion_controller.sv
dv/gap_verify_motion_controller_tb.sv
